>>> hw/rtl/edf_pkg.sv
`default_nettype none

package edf_pkg;

   localparam int TASK_COUNT = 8;
   localparam int TASK_W     = $clog2(TASK_COUNT);
   localparam int TIME_WIDTH = 48;

   localparam int FUNC_W  = 1;
   localparam int DL_W    = 32;
   localparam int BUD_W   = 32;
   localparam int QUANT_W = 20;
   localparam int SHIFT_W = 3;
   localparam int THR_W   = BUD_W + (2 ** SHIFT_W);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_QUANTUM = 1'b0;
   localparam logic CSR_SLACK   = 1'b1;

   localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b1;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 20'd10000;
   localparam logic [SHIFT_W-1:0] SLACK_RESET   = 3'd1;

   typedef struct packed {
      logic [QUANT_W-1:0] quantum;
      logic [SHIFT_W-1:0] slack_shift;
   } cfg_type;

   typedef struct packed {
      logic [DL_W-1:0]  rel_deadline;
      logic [BUD_W-1:0] budget;
   } task_entry_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] deadline;
      logic [TIME_WIDTH-1:0] executed;
   } time_entry_type;

   localparam int TASK_ENTRY_W = $bits(task_entry_type);
   localparam int TIME_ENTRY_W = $bits(time_entry_type);

endpackage

`default_nettype wire

>>> hw/rtl/edf_ram.sv
`default_nettype none

module edf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/edf_csr.sv
`default_nettype none

module edf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [edf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [edf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [edf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output edf_pkg::cfg_type                      cfg
);

   logic [edf_pkg::QUANT_W-1:0] quantum_ff;
   logic [edf_pkg::SHIFT_W-1:0] slack_ff;
   logic                        reg_sel;
   logic                        wr_en;

   assign reg_sel = paddr[edf_pkg::CSR_ADDR_W-1];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= edf_pkg::QUANTUM_RESET;
         slack_ff   <= edf_pkg::SLACK_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            edf_pkg::CSR_QUANTUM: quantum_ff <= pwdata[edf_pkg::QUANT_W-1:0];
            edf_pkg::CSR_SLACK:   slack_ff   <= pwdata[edf_pkg::SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         edf_pkg::CSR_QUANTUM: prdata = edf_pkg::CSR_DATA_W'(quantum_ff);
         edf_pkg::CSR_SLACK:   prdata = edf_pkg::CSR_DATA_W'(slack_ff);
         default:              prdata = '0;
      endcase
   end

   assign cfg.quantum     = quantum_ff;
   assign cfg.slack_shift = slack_ff;

endmodule

`default_nettype wire

>>> hw/rtl/edf_engine.sv
`default_nettype none

module edf_engine (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire edf_pkg::cfg_type                 cfg,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [edf_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [edf_pkg::TASK_W-1:0]       req_task_index,
   input  wire logic [edf_pkg::DL_W-1:0]         req_relative_deadline,
   input  wire logic [edf_pkg::BUD_W-1:0]        req_runtime_budget,
   input  wire logic [edf_pkg::TASK_COUNT-1:0]   req_alive_mask,
   input  wire logic [edf_pkg::TIME_WIDTH-1:0]   req_current_time,
   output logic                                  rsp_valid,
   output logic                                  rsp_task_valid,
   output logic      [edf_pkg::TASK_W-1:0]       rsp_selected_task,
   output logic                                  rsp_high_freq
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_WR,
      ST_CH_RD,
      ST_CH_WR,
      ST_SCAN,
      ST_DRAIN,
      ST_SELECT,
      ST_HINT_RD,
      ST_HINT_ADD,
      ST_HINT_CMP
   } state_type;

   state_type state_ff;

   logic [edf_pkg::TASK_W-1:0]     idx_ff;
   logic [edf_pkg::DL_W-1:0]       rel_ff;
   logic [edf_pkg::BUD_W-1:0]      bud_ff;
   logic [edf_pkg::TASK_COUNT-1:0] alive_ff;
   logic [edf_pkg::TASK_COUNT-1:0] added_ff;
   logic                           resel_ff;
   logic [edf_pkg::TIME_WIDTH-1:0] now_ff;
   logic [edf_pkg::TASK_COUNT-1:0] last_alive_ff;
   logic [edf_pkg::TASK_W-1:0]     run_ff;
   logic                           run_valid_ff;
   logic [edf_pkg::TASK_COUNT-1:0] exec_valid_ff;
   logic [edf_pkg::TASK_W-1:0]     scan_idx_ff;
   logic                           pend_ff;
   logic [edf_pkg::TASK_W-1:0]     pend_idx_ff;
   logic                           found_ff;
   logic [edf_pkg::TIME_WIDTH-1:0] best_ff;
   logic [edf_pkg::TASK_W-1:0]     best_idx_ff;
   logic [edf_pkg::TASK_W-1:0]     rd_addr_ff;
   logic [edf_pkg::TIME_WIDTH:0]   lhs_ff;
   logic [edf_pkg::THR_W-1:0]      thr_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_task_valid_ff;
   logic [edf_pkg::TASK_W-1:0]     rsp_task_ff;
   logic                           rsp_high_ff;

   logic                           rd_en;
   logic [edf_pkg::TASK_W-1:0]     rd_addr;
   logic                           task_wr_en;
   edf_pkg::task_entry_type        task_wr_data;
   edf_pkg::task_entry_type        task_rd;
   logic                           time_wr_en;
   logic [edf_pkg::TASK_W-1:0]     time_wr_addr;
   edf_pkg::time_entry_type        time_wr_data;
   edf_pkg::time_entry_type        time_rd;

   logic [edf_pkg::TIME_WIDTH-1:0] exec_rd;
   logic [edf_pkg::TIME_WIDTH-1:0] scan_dl;
   logic                           scan_take;
   logic                           scan_wr;
   logic [edf_pkg::TIME_WIDTH:0]   rhs;
   logic                           hint_high;
   logic [edf_pkg::TASK_COUNT-1:0] tick_added;
   logic                           tick_resel;

   edf_ram #(
      .WIDTH (edf_pkg::TASK_ENTRY_W),
      .DEPTH (edf_pkg::TASK_COUNT)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (task_wr_en),
      .wr_addr (idx_ff),
      .wr_data (task_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (task_rd)
   );

   edf_ram #(
      .WIDTH (edf_pkg::TIME_ENTRY_W),
      .DEPTH (edf_pkg::TASK_COUNT)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (time_wr_en),
      .wr_addr (time_wr_addr),
      .wr_data (time_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (time_rd)
   );

   // An executed time that was never written reads as zero.
   assign exec_rd   = exec_valid_ff[rd_addr_ff] ? time_rd.executed : '0;
   assign scan_dl   = added_ff[pend_idx_ff]
                    ? now_ff + edf_pkg::TIME_WIDTH'(task_rd.rel_deadline)
                    : time_rd.deadline;
   assign scan_take = pend_ff && alive_ff[pend_idx_ff] && (!found_ff || (scan_dl < best_ff));
   assign scan_wr   = pend_ff && added_ff[pend_idx_ff];
   assign rhs       = {1'b0, now_ff} + (edf_pkg::TIME_WIDTH + 1)'(thr_ff);
   assign hint_high = !(lhs_ff > rhs);

   assign tick_added = req_alive_mask & ~last_alive_ff;
   assign tick_resel = (tick_added != '0) || !run_valid_ff || !req_alive_mask[run_ff];

   assign task_wr_data.rel_deadline = rel_ff;
   assign task_wr_data.budget       = bud_ff;

   always_comb begin
      rd_en        = 1'b0;
      rd_addr      = run_ff;
      task_wr_en   = 1'b0;
      time_wr_en   = 1'b0;
      time_wr_addr = run_ff;
      time_wr_data.deadline = time_rd.deadline;
      time_wr_data.executed = exec_rd + edf_pkg::TIME_WIDTH'(cfg.quantum);
      case (state_ff)
         ST_LD_RD: begin
            rd_en      = 1'b1;
            rd_addr    = idx_ff;
            task_wr_en = 1'b1;
         end
         ST_LD_WR: begin
            time_wr_en            = 1'b1;
            time_wr_addr          = idx_ff;
            time_wr_data.deadline = edf_pkg::TIME_WIDTH'(rel_ff);
            time_wr_data.executed = exec_rd;
         end
         ST_CH_RD: begin
            rd_en = 1'b1;
         end
         ST_CH_WR: begin
            time_wr_en = 1'b1;
         end
         ST_SCAN, ST_DRAIN: begin
            rd_en                 = (state_ff == ST_SCAN);
            rd_addr               = scan_idx_ff;
            time_wr_en            = scan_wr;
            time_wr_addr          = pend_idx_ff;
            time_wr_data.deadline = scan_dl;
            time_wr_data.executed = '0;
         end
         ST_HINT_RD: begin
            rd_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_alive_ff <= edf_pkg::TASK_COUNT'(1);
         run_ff        <= '0;
         run_valid_ff  <= 1'b1;
         exec_valid_ff <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rd_addr_ff   <= rd_addr;
         if (time_wr_en) begin
            exec_valid_ff[time_wr_addr] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  idx_ff <= req_task_index;
                  rel_ff <= req_relative_deadline;
                  bud_ff <= req_runtime_budget;
                  if (req_func == edf_pkg::FUNC_LOAD) begin
                     state_ff <= ST_LD_RD;
                  end else begin
                     alive_ff      <= req_alive_mask;
                     added_ff      <= tick_added;
                     resel_ff      <= tick_resel;
                     now_ff        <= req_current_time;
                     last_alive_ff <= req_alive_mask;
                     found_ff      <= 1'b0;
                     best_idx_ff   <= '0;
                     scan_idx_ff   <= '0;
                     state_ff      <= run_valid_ff ? ST_CH_RD : ST_SCAN;
                  end
               end
            end
            ST_LD_RD: state_ff <= ST_LD_WR;
            ST_LD_WR: state_ff <= ST_IDLE;
            ST_CH_RD: state_ff <= ST_CH_WR;
            ST_CH_WR: state_ff <= resel_ff ? ST_SCAN : ST_HINT_RD;
            ST_SCAN: begin
               pend_ff     <= 1'b1;
               pend_idx_ff <= scan_idx_ff;
               scan_idx_ff <= scan_idx_ff + 1'b1;
               if (scan_take) begin
                  found_ff    <= 1'b1;
                  best_ff     <= scan_dl;
                  best_idx_ff <= pend_idx_ff;
               end
               if (scan_idx_ff == edf_pkg::TASK_W'(edf_pkg::TASK_COUNT - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               pend_ff <= 1'b0;
               if (scan_take) begin
                  found_ff    <= 1'b1;
                  best_ff     <= scan_dl;
                  best_idx_ff <= pend_idx_ff;
               end
               state_ff <= ST_SELECT;
            end
            ST_SELECT: begin
               run_ff       <= best_idx_ff;
               run_valid_ff <= found_ff;
               if (found_ff) begin
                  state_ff <= ST_HINT_RD;
               end else begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_task_valid_ff <= 1'b0;
                  rsp_task_ff       <= '0;
                  rsp_high_ff       <= 1'b0;
                  state_ff          <= ST_IDLE;
               end
            end
            ST_HINT_RD: state_ff <= ST_HINT_ADD;
            ST_HINT_ADD: begin
               lhs_ff   <= {1'b0, time_rd.deadline} + {1'b0, exec_rd};
               thr_ff   <= edf_pkg::THR_W'(task_rd.budget)
                         + (edf_pkg::THR_W'(task_rd.budget) << cfg.slack_shift);
               state_ff <= ST_HINT_CMP;
            end
            ST_HINT_CMP: begin
               rsp_valid_ff      <= 1'b1;
               rsp_task_valid_ff <= 1'b1;
               rsp_task_ff       <= run_ff;
               rsp_high_ff       <= hint_high;
               state_ff          <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_task_valid    = rsp_task_valid_ff;
   assign rsp_selected_task = rsp_task_ff;
   assign rsp_high_freq     = rsp_high_ff;

endmodule

`default_nettype wire

>>> hw/rtl/edf_scheduler_with_dvfs.sv
`default_nettype none

// Channel    Handshake               Payload
// request    start, busy             req_func, req_task_index, req_relative_deadline,
//                                    req_runtime_budget, req_alive_mask, req_current_time
// response   rsp_valid (one cycle)   rsp_task_valid, rsp_selected_task, rsp_high_freq
// config     psel, penable, pwrite   paddr, pwdata, prdata, pready (always high)
//
// A load writes the task memory, then the time memory, before the next request is accepted.
// A tick charges the running task, if any, with a read and write on the time memory;
// when a new pick is needed it scans all deadlines through the memory read port, one
// task per cycle, then drains and selects; if a task runs, three hint steps follow.
// Reset is synchronous; after it every executed time reads as zero and task zero runs.
// The response is shown for one cycle and cannot be stalled.

module edf_scheduler_with_dvfs (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [edf_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [edf_pkg::TASK_W-1:0]       req_task_index,
   input  wire logic [edf_pkg::DL_W-1:0]         req_relative_deadline,
   input  wire logic [edf_pkg::BUD_W-1:0]        req_runtime_budget,
   input  wire logic [edf_pkg::TASK_COUNT-1:0]   req_alive_mask,
   input  wire logic [edf_pkg::TIME_WIDTH-1:0]   req_current_time,
   output logic                                  rsp_valid,
   output logic                                  rsp_task_valid,
   output logic      [edf_pkg::TASK_W-1:0]       rsp_selected_task,
   output logic                                  rsp_high_freq,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [edf_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [edf_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [edf_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready
);

   edf_pkg::cfg_type cfg;

   edf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   edf_engine u_engine (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_task_index        (req_task_index),
      .req_relative_deadline (req_relative_deadline),
      .req_runtime_budget    (req_runtime_budget),
      .req_alive_mask        (req_alive_mask),
      .req_current_time      (req_current_time),
      .rsp_valid             (rsp_valid),
      .rsp_task_valid        (rsp_task_valid),
      .rsp_selected_task     (rsp_selected_task),
      .rsp_high_freq         (rsp_high_freq)
   );

endmodule

`default_nettype wire

>>> hw/rtl/edf_checker.sv
`default_nettype none

module edf_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_task_valid,
   input wire logic [edf_pkg::TASK_W-1:0] rsp_selected_task,
   input wire logic                       rsp_high_freq
);

   // A response transfer always coincides with the block being ready again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_task_valid) |-> ((rsp_selected_task == '0) && !rsp_high_freq))
      else $error("invalid response carries nonzero fields");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

endmodule

bind edf_scheduler_with_dvfs edf_checker u_edf_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_task_valid    (rsp_task_valid),
   .rsp_selected_task (rsp_selected_task),
   .rsp_high_freq     (rsp_high_freq)
);

`default_nettype wire

>>> tb/tb_edf_scheduler_with_dvfs.sv
`timescale 1ns / 100ps

module tb_edf_scheduler_with_dvfs;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 250;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [edf_pkg::CSR_ADDR_W-1:0] QUANTUM_ADDR = {edf_pkg::CSR_QUANTUM, 2'b00};
   localparam logic [edf_pkg::CSR_ADDR_W-1:0] SLACK_ADDR   = {edf_pkg::CSR_SLACK, 2'b00};
   localparam logic [edf_pkg::QUANT_W-1:0]    QUANTUM_MAX  = '1;
   localparam logic [edf_pkg::SHIFT_W-1:0]    SLACK_MAX    = '1;
   localparam logic [edf_pkg::TIME_WIDTH-1:0] TIME_MAX     = '1;

   typedef struct packed {
      logic                        task_valid;
      logic [edf_pkg::TASK_W-1:0]  selected_task;
      logic                        high_freq;
   } pick_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [edf_pkg::FUNC_W-1:0]         req_func;
   logic [edf_pkg::TASK_W-1:0]         req_task_index;
   logic [edf_pkg::DL_W-1:0]           req_relative_deadline;
   logic [edf_pkg::BUD_W-1:0]          req_runtime_budget;
   logic [edf_pkg::TASK_COUNT-1:0]     req_alive_mask;
   logic [edf_pkg::TIME_WIDTH-1:0]     req_current_time;
   logic                               rsp_valid;
   logic                               rsp_task_valid;
   logic [edf_pkg::TASK_W-1:0]         rsp_selected_task;
   logic                               rsp_high_freq;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [edf_pkg::CSR_ADDR_W-1:0]     paddr;
   logic [edf_pkg::CSR_DATA_W-1:0]     pwdata;
   logic [edf_pkg::CSR_DATA_W-1:0]     prdata;
   logic                               pready;

   edf_scheduler_with_dvfs DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_task_index        (req_task_index),
      .req_relative_deadline (req_relative_deadline),
      .req_runtime_budget    (req_runtime_budget),
      .req_alive_mask        (req_alive_mask),
      .req_current_time      (req_current_time),
      .rsp_valid             (rsp_valid),
      .rsp_task_valid        (rsp_task_valid),
      .rsp_selected_task     (rsp_selected_task),
      .rsp_high_freq         (rsp_high_freq),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always #6 clock = ~clock;

   // Scheduler state as the testbench tracks it.
   logic [edf_pkg::QUANT_W-1:0]    quantum_cfg;
   logic [edf_pkg::SHIFT_W-1:0]    slack_cfg;
   logic [edf_pkg::TASK_COUNT-1:0] last_alive;
   logic [edf_pkg::TASK_W-1:0]     running_idx;
   logic                           running_ok;
   logic [edf_pkg::TIME_WIDTH-1:0] executed_table [edf_pkg::TASK_COUNT];
   logic [edf_pkg::TIME_WIDTH-1:0] deadline_table [edf_pkg::TASK_COUNT];
   logic [edf_pkg::DL_W-1:0]       rel_table      [edf_pkg::TASK_COUNT];
   logic [edf_pkg::BUD_W-1:0]      budget_table   [edf_pkg::TASK_COUNT];

   pick_type expected_picks[$];

   int  errors = 0;
   int  cycles = 0;
   int  loads = 0;
   int  ticks = 0;
   int  settings = 0;
   int  checked = 0;
   int  idle_picks = 0;
   int  low_hints = 0;
   bit  no_gaps = 1'b0;

   logic [edf_pkg::TASK_COUNT-1:0] tb_alive = '0;
   logic [edf_pkg::TIME_WIDTH-1:0] tb_now = '0;

   function automatic void note_error(string msg);
      errors++;
      if (errors <= 10) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic void model_reset();
      quantum_cfg = edf_pkg::QUANTUM_RESET;
      slack_cfg   = edf_pkg::SLACK_RESET;
      last_alive  = edf_pkg::TASK_COUNT'(1);
      running_idx = '0;
      running_ok  = 1'b1;
      for (int i = 0; i < edf_pkg::TASK_COUNT; i++) begin
         executed_table[i] = '0;
         deadline_table[i] = '0;
         rel_table[i]      = '0;
         budget_table[i]   = '0;
      end
   endfunction

   function automatic void load_entry(logic [edf_pkg::TASK_W-1:0] idx,
                                      logic [edf_pkg::DL_W-1:0] rel,
                                      logic [edf_pkg::BUD_W-1:0] bud);
      rel_table[idx]      = rel;
      budget_table[idx]   = bud;
      deadline_table[idx] = edf_pkg::TIME_WIDTH'(rel);
   endfunction

   function automatic pick_type predict_tick(logic [edf_pkg::TASK_COUNT-1:0] alive,
                                             logic [edf_pkg::TIME_WIDTH-1:0] now);
      logic [edf_pkg::TASK_COUNT-1:0] added;
      logic [edf_pkg::TIME_WIDTH-1:0] best;
      logic [edf_pkg::TASK_W-1:0]     best_idx;
      logic                           found;
      logic [63:0]                    bud;
      logic [63:0]                    lhs;
      logic [63:0]                    rhs;
      pick_type                       res;
      if (running_ok) begin
         executed_table[running_idx] = executed_table[running_idx]
                                     + edf_pkg::TIME_WIDTH'(quantum_cfg);
      end
      added = alive & ~last_alive;
      for (int i = 0; i < edf_pkg::TASK_COUNT; i++) begin
         if (added[i]) begin
            deadline_table[i] = now + edf_pkg::TIME_WIDTH'(rel_table[i]);
            executed_table[i] = '0;
         end
      end
      if (added != '0 || !running_ok || !alive[running_idx]) begin
         found    = 1'b0;
         best     = '0;
         best_idx = '0;
         for (int i = 0; i < edf_pkg::TASK_COUNT; i++) begin
            if (alive[i] && (!found || deadline_table[i] < best)) begin
               found    = 1'b1;
               best     = deadline_table[i];
               best_idx = edf_pkg::TASK_W'(i);
            end
         end
         running_ok  = found;
         running_idx = best_idx;
      end
      last_alive = alive;
      res = '0;
      if (running_ok) begin
         bud = 64'(budget_table[running_idx]);
         lhs = 64'(deadline_table[running_idx]) + 64'(executed_table[running_idx]);
         rhs = 64'(now) + bud + (bud << slack_cfg);
         res.task_valid    = 1'b1;
         res.selected_task = running_idx;
         res.high_freq     = !(lhs > rhs);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d picks outstanding.",
                  cycles, expected_picks.size());
         $display("edf_scheduler_with_dvfs test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      pick_type exp_pick;
      if (!reset && rsp_valid) begin
         if (expected_picks.size() == 0) begin
            note_error($sformatf("unexpected pick valid=%0b task=%0d high=%0b",
                                 rsp_task_valid, rsp_selected_task, rsp_high_freq));
         end else begin
            exp_pick = expected_picks.pop_front();
            checked++;
            if (!rsp_task_valid) idle_picks++;
            else if (!rsp_high_freq) low_hints++;
            if (rsp_task_valid !== exp_pick.task_valid ||
                rsp_selected_task !== exp_pick.selected_task ||
                rsp_high_freq !== exp_pick.high_freq) begin
               note_error($sformatf(
                  "pick %0d: expected valid=%0b task=%0d high=%0b, got valid=%0b task=%0d high=%0b",
                  checked, exp_pick.task_valid, exp_pick.selected_task, exp_pick.high_freq,
                  rsp_task_valid, rsp_selected_task, rsp_high_freq));
            end
         end
      end
   end

   task automatic send_item(logic [edf_pkg::FUNC_W-1:0] func,
                            logic [edf_pkg::TASK_W-1:0] idx,
                            logic [edf_pkg::DL_W-1:0] rel, logic [edf_pkg::BUD_W-1:0] bud,
                            logic [edf_pkg::TASK_COUNT-1:0] alive,
                            logic [edf_pkg::TIME_WIDTH-1:0] now);
      start                 <= 1'b1;
      req_func              <= func;
      req_task_index        <= idx;
      req_relative_deadline <= rel;
      req_runtime_budget    <= bud;
      req_alive_mask        <= alive;
      req_current_time      <= now;
      do @(posedge clock); while (busy);
      if (func == edf_pkg::FUNC_LOAD) begin
         load_entry(idx, rel, bud);
         loads++;
      end else begin
         expected_picks.push_back(predict_tick(alive, now));
         ticks++;
      end
   endtask

   task automatic idle_gap();
      int r;
      int n;
      if (no_gaps) return;
      r = $urandom_range(0, 99);
      if (r < 55) n = 0;
      else if (r < 90) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic load_task(logic [edf_pkg::TASK_W-1:0] idx, logic [edf_pkg::DL_W-1:0] rel,
                            logic [edf_pkg::BUD_W-1:0] bud);
      send_item(edf_pkg::FUNC_LOAD, idx, rel, bud, edf_pkg::TASK_COUNT'($urandom),
                edf_pkg::TIME_WIDTH'({$urandom, $urandom}));
      idle_gap();
   endtask

   task automatic tick(logic [edf_pkg::TASK_COUNT-1:0] alive,
                       logic [edf_pkg::TIME_WIDTH-1:0] now);
      send_item(edf_pkg::FUNC_TICK, edf_pkg::TASK_W'($urandom), $urandom, $urandom,
                alive, now);
      idle_gap();
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      while (busy || expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [edf_pkg::CSR_ADDR_W-1:0] addr,
                             logic [edf_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [edf_pkg::CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic check_csr(logic [edf_pkg::CSR_ADDR_W-1:0] addr,
                            logic [edf_pkg::CSR_DATA_W-1:0] exp_value);
      logic [edf_pkg::CSR_DATA_W-1:0] rd;
      csr_access(1'b0, addr, '0, rd);
      if (rd !== exp_value) begin
         note_error($sformatf("register at %0d read %0h, expected %0h", addr, rd, exp_value));
      end
   endtask

   task automatic set_config(logic [edf_pkg::QUANT_W-1:0] quantum,
                             logic [edf_pkg::SHIFT_W-1:0] shift);
      logic [edf_pkg::CSR_DATA_W-1:0] unused;
      wait_quiet();
      csr_access(1'b1, QUANTUM_ADDR, edf_pkg::CSR_DATA_W'(quantum), unused);
      csr_access(1'b1, SLACK_ADDR, edf_pkg::CSR_DATA_W'(shift), unused);
      quantum_cfg = quantum;
      slack_cfg   = shift;
      settings++;
      check_csr(QUANTUM_ADDR, edf_pkg::CSR_DATA_W'(quantum));
      check_csr(SLACK_ADDR, edf_pkg::CSR_DATA_W'(shift));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_csr_reset_values();
      check_csr(QUANTUM_ADDR, edf_pkg::CSR_DATA_W'(edf_pkg::QUANTUM_RESET));
      check_csr(SLACK_ADDR, edf_pkg::CSR_DATA_W'(edf_pkg::SLACK_RESET));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Every entry is loaded before the first tick, so no tick reads an unwritten entry.
   task automatic test_table_load();
      load_task(3'd0, 32'd0, 32'd0);
      load_task(3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      load_task(3'd2, 32'd1000, 32'd100);
      load_task(3'd3, 32'd1000, 32'd100);
      load_task(3'd4, 32'd50000, 32'd5000);
      load_task(3'd5, 32'd50000, 32'd30000);
      load_task(3'd6, 32'd20000, 32'd0);
      load_task(3'd7, 32'd300000, 32'd1000);
   endtask

   task automatic test_directed_ticks();
      tick(8'h01, 48'd0);
      tick(8'h00, 48'd10);
      tick(8'h00, 48'd20);
      tick(8'h0C, 48'd100);
      tick(8'h0C, 48'd200);
      tick(8'h08, 48'd300);
      tick(8'hFF, TIME_MAX - 48'd100);
      tick(8'hFF, TIME_MAX);
      tick(8'h80, 48'd0);
      tick(8'hF0, 48'd1000);
      load_task(3'd7, 32'd5, 32'd2);
      tick(8'hF0, 48'd2000);
   endtask

   task automatic test_config_extremes();
      set_config(20'd1, 3'd0);
      tick(8'h5A, 48'h0000_1234_5678);
      tick(8'h5A, 48'h0000_1234_5679);
      set_config(QUANTUM_MAX, SLACK_MAX);
      tick(8'hA5, TIME_MAX);
      tick(8'h24, 48'h8000_0000_0000);
   endtask

   task automatic random_item();
      int r;
      logic [edf_pkg::DL_W-1:0]  rel;
      logic [edf_pkg::BUD_W-1:0] bud;
      if ($urandom_range(0, 99) < 15) begin
         r = $urandom_range(0, 9);
         if (r == 0) rel = '0;
         else if (r == 1) rel = '1;
         else if (r < 4) rel = $urandom;
         else rel = $urandom_range(0, 1 << 21);
         r = $urandom_range(0, 9);
         if (r == 0) bud = '0;
         else if (r == 1) bud = '1;
         else if (r == 2) bud = $urandom;
         else bud = rel >> $urandom_range(0, 8);
         load_task(edf_pkg::TASK_W'($urandom), rel, bud);
      end else begin
         r = $urandom_range(0, 19);
         if (r == 0) tb_alive = '0;
         else if (r == 1) tb_alive = '1;
         else if (r < 4) tb_alive = edf_pkg::TASK_COUNT'($urandom);
         else if (r >= 10) tb_alive[$urandom_range(0, edf_pkg::TASK_COUNT - 1)] ^= 1'b1;
         r = $urandom_range(0, 49);
         if (r == 0) tb_now = edf_pkg::TIME_WIDTH'({$urandom, $urandom});
         else if (r == 1) tb_now = TIME_MAX
                                 - edf_pkg::TIME_WIDTH'($urandom_range(0, 1 << 20));
         else tb_now = tb_now + edf_pkg::TIME_WIDTH'($urandom_range(0, 65535));
         tick(tb_alive, tb_now);
      end
   endtask

   // Each phase starts from a drained block with a fresh register setting.
   task automatic test_random_traffic();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: set_config(edf_pkg::QUANTUM_RESET, edf_pkg::SLACK_RESET);
            1: set_config(20'd1, 3'd0);
            2: set_config(QUANTUM_MAX, SLACK_MAX);
            default: set_config(edf_pkg::QUANT_W'($urandom_range(1, 1048575)),
                                edf_pkg::SHIFT_W'($urandom_range(0, 7)));
         endcase
         no_gaps = (p == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            random_item();
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset                 <= 1'b1;
      start                 <= 1'b0;
      req_func              <= edf_pkg::FUNC_LOAD;
      req_task_index        <= '0;
      req_relative_deadline <= '0;
      req_runtime_budget    <= '0;
      req_alive_mask        <= '0;
      req_current_time      <= '0;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_csr_reset_values();
      test_table_load();
      test_directed_ticks();
      test_config_extremes();
      test_random_traffic();
      wait_quiet();

      $display("Sent %0d table loads and %0d ticks under %0d register settings.",
               loads, ticks, settings);
      $display("Checked %0d picks: %0d with no ready task, %0d asking for low frequency.",
               checked, idle_picks, low_hints);
      if (errors == 0) begin
         $display("edf_scheduler_with_dvfs test passed");
      end else begin
         $display("%0d mismatches in total.", errors);
         $display("edf_scheduler_with_dvfs test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/edf_pkg.sv
hw/rtl/edf_ram.sv
hw/rtl/edf_csr.sv
hw/rtl/edf_engine.sv
hw/rtl/edf_scheduler_with_dvfs.sv
hw/rtl/edf_checker.sv
tb/tb_edf_scheduler_with_dvfs.sv
